// ----- hw/rtl/cube_direction_to_face_uv_macros.svh -----
// Assertion macros used by the checker of the cube face block.
`ifndef CUBE_DIRECTION_TO_FACE_UV_MACROS_SVH
`define CUBE_DIRECTION_TO_FACE_UV_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define CDFUV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdfuv: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define CDFUV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdfuv: next-cycle check failed");

`endif

// ----- hw/rtl/cdfuv_pkg.sv -----
// Shared constants, types and the arctangent table of the cube face block.
package cdfuv_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int FRAC_BITS    = 16;
  localparam int ANGLE_FRAC   = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int DP_W         = 64;                 // CORDIC x/y datapath
  localparam int ANG_W        = ANGLE_FRAC + 4;     // angle accumulator
  localparam int MAG_W        = COORD_WIDTH;        // |component| fits unsigned
  localparam int NUM_W        = COORD_WIDTH + 1;    // negated minor needs one more bit
  localparam int SCALE_SHIFT  = 60 - COORD_WIDTH;
  localparam int ROUND_SHIFT  = ANGLE_FRAC - FRAC_BITS;
  localparam int OUT_W        = 18;
  localparam int FACE_W       = 3;
  localparam int IN_TDATA_W   = 3 * COORD_WIDTH;
  localparam int OUT_FIELDS_W = FACE_W + 2 * OUT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic signed [ANG_W-1:0] ANG_LIM  = ANG_W'(1) << ANGLE_FRAC;
  localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(1) << (ROUND_SHIFT - 1);

  typedef enum logic [FACE_W-1:0] {
    FACE_NEG_X = 3'd0,
    FACE_POS_X = 3'd1,
    FACE_NEG_Y = 3'd2,
    FACE_POS_Y = 3'd3,
    FACE_NEG_Z = 3'd4,
    FACE_POS_Z = 3'd5
  } face_t;

  typedef struct packed {
    logic signed [DP_W-1:0]  x;
    logic signed [DP_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } lane_t;

  typedef struct packed {
    face_t face;
    logic  degen;
  } side_t;

  // round(2^30 * atan(2^-i) * 4/pi)
  function automatic logic signed [ANG_W-1:0] atan_coef(input logic [STEP_W-1:0] step);
    logic signed [ANG_W-1:0] c;
    case (step)
      5'd0:    c = ANG_W'(1073741824);
      5'd1:    c = ANG_W'(633866811);
      5'd2:    c = ANG_W'(334917815);
      5'd3:    c = ANG_W'(170009512);
      5'd4:    c = ANG_W'(85334662);
      5'd5:    c = ANG_W'(42708931);
      5'd6:    c = ANG_W'(21359677);
      5'd7:    c = ANG_W'(10680490);
      5'd8:    c = ANG_W'(5340327);
      5'd9:    c = ANG_W'(2670173);
      5'd10:   c = ANG_W'(1335088);
      5'd11:   c = ANG_W'(667544);
      5'd12:   c = ANG_W'(333772);
      5'd13:   c = ANG_W'(166886);
      5'd14:   c = ANG_W'(83443);
      5'd15:   c = ANG_W'(41722);
      5'd16:   c = ANG_W'(20861);
      5'd17:   c = ANG_W'(10430);
      5'd18:   c = ANG_W'(5215);
      5'd19:   c = ANG_W'(2608);
      5'd20:   c = ANG_W'(1304);
      5'd21:   c = ANG_W'(652);
      5'd22:   c = ANG_W'(326);
      5'd23:   c = ANG_W'(163);
      5'd24:   c = ANG_W'(81);
      5'd25:   c = ANG_W'(41);
      5'd26:   c = ANG_W'(20);
      5'd27:   c = ANG_W'(10);
      5'd28:   c = ANG_W'(5);
      5'd29:   c = ANG_W'(3);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/cube_direction_to_face_uv.sv -----
// Top level of the cube face block: axis select, CORDIC cell chain, rounding, output skid.
//
// Takes a direction (dir_x, dir_y, dir_z) of any nonzero length, picks the cube
// face of the largest magnitude (ties go to x, then y), and returns the face code
// (0 -x, 1 +x, 2 -y, 3 +y, 4 -z, 5 +z) with the warped coordinates
// u, v = atan(minor / |major|) * 4/pi as signed Q1.16 values in [-1, 1].
// A zero vector returns face 1, u = v = 0 and the degenerate flag in out_tuser.
// The block takes one request every cycle while out_tready stays high; a result
// passes the selection stage, which loads at the edge that accepts its request,
// then one cell per CORDIC step in a chain of 30, one rounding stage and one
// output register before it shows on the output. Every stage advances together;
// a two-entry output buffer (register plus skid) takes the result at the chain
// end, and in_tready drops only while the skid entry is occupied, so in_tready
// is registered and never waits combinationally on out_tready. Results leave
// in request order.
module cube_direction_to_face_uv (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [31:0] dir_x, [63:32] dir_y, [95:64] dir_z
  input  logic [cdfuv_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [2:0] face, [20:3] coord_u, [38:21] coord_v, [39] zero pad
  output logic [cdfuv_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] degenerate
  output logic                                 out_tuser
);
  import cdfuv_pkg::*;

  // Advance the whole pipeline whenever the skid entry is free.
  logic en;

  logic                    sel_valid;
  side_t                   sel_side;
  logic        [MAG_W-1:0] sel_major;
  logic signed [NUM_W-1:0] sel_num_u, sel_num_v;

  logic  chain_valid [CORDIC_STEPS+1];
  side_t chain_side  [CORDIC_STEPS+1];
  lane_t chain_u     [CORDIC_STEPS+1];
  lane_t chain_v     [CORDIC_STEPS+1];

  logic                    rnd_valid;
  side_t                   rnd_side;
  logic signed [OUT_W-1:0] rnd_u, rnd_v;

  logic [OUT_TDATA_W-1:0] rnd_data;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;
  logic                   out_user_r, out_user_nxt, skid_user_r, skid_user_nxt;
  logic                   out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic                   out_take;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  cdfuv_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .dir_x    (in_tdata[COORD_WIDTH-1:0]),
    .dir_y    (in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .dir_z    (in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .valid_r  (sel_valid),
    .side_r   (sel_side),
    .major_r  (sel_major),
    .num_u_r  (sel_num_u),
    .num_v_r  (sel_num_v)
  );

  // Seed the chain: both operands scaled up to the common fixed point.
  always_comb begin
    chain_valid[0] = sel_valid;
    chain_side[0]  = sel_side;
    chain_u[0].x   = DP_W'(sel_major) << SCALE_SHIFT;
    chain_u[0].y   = DP_W'(sel_num_u) <<< SCALE_SHIFT;
    chain_u[0].z   = '0;
    chain_v[0].x   = DP_W'(sel_major) << SCALE_SHIFT;
    chain_v[0].y   = DP_W'(sel_num_v) <<< SCALE_SHIFT;
    chain_v[0].z   = '0;
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    cdfuv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .step     (STEP_W'(g)),
      .in_valid (chain_valid[g]),
      .in_side  (chain_side[g]),
      .in_u     (chain_u[g]),
      .in_v     (chain_v[g]),
      .valid_r  (chain_valid[g+1]),
      .side_r   (chain_side[g+1]),
      .u_r      (chain_u[g+1]),
      .v_r      (chain_v[g+1])
    );
  end

  cdfuv_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (chain_valid[CORDIC_STEPS]),
    .in_side  (chain_side[CORDIC_STEPS]),
    .z_u      (chain_u[CORDIC_STEPS].z),
    .z_v      (chain_v[CORDIC_STEPS].z),
    .valid_r  (rnd_valid),
    .side_r   (rnd_side),
    .u_r      (rnd_u),
    .v_r      (rnd_v)
  );

  assign rnd_data = OUT_TDATA_W'({rnd_v, rnd_u, rnd_side.face});

  // Output register plus skid: a result arriving while the register is
  // stalled parks in the skid entry and holds off new requests.
  always_comb begin
    out_take       = out_valid_r && out_tready;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_user_nxt  = skid_user_r;
    if (en && rnd_valid) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rnd_data;
        out_user_nxt  = rnd_side.degen;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = rnd_data;
        skid_user_nxt  = rnd_side.degen;
      end
    end else if (skid_valid_r && out_take) begin
      out_data_nxt   = skid_data_r;
      out_user_nxt   = skid_user_r;
      skid_valid_nxt = 1'b0;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
    skid_data_r <= skid_data_nxt;
    skid_user_r <= skid_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- hw/rtl/cdfuv_select.sv -----
// Front stage: major axis, face code and signed minor numerators.
module cdfuv_select (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [cdfuv_pkg::COORD_WIDTH-1:0] dir_x,
  input  logic signed [cdfuv_pkg::COORD_WIDTH-1:0] dir_y,
  input  logic signed [cdfuv_pkg::COORD_WIDTH-1:0] dir_z,
  output logic                                 valid_r,
  output cdfuv_pkg::side_t                     side_r,
  output logic        [cdfuv_pkg::MAG_W-1:0]   major_r,
  output logic signed [cdfuv_pkg::NUM_W-1:0]   num_u_r,
  output logic signed [cdfuv_pkg::NUM_W-1:0]   num_v_r
);
  import cdfuv_pkg::*;

  logic signed [NUM_W-1:0] sx, sy, sz;
  logic        [MAG_W-1:0] mx, my, mz, m_xy;
  logic                    pick_y, pick_z;
  side_t                   side_nxt;
  logic        [MAG_W-1:0] major_nxt;
  logic signed [NUM_W-1:0] num_u_nxt, num_v_nxt;

  always_comb begin
    sx = NUM_W'(dir_x);
    sy = NUM_W'(dir_y);
    sz = NUM_W'(dir_z);
    mx = MAG_W'(sx[NUM_W-1] ? -sx : sx);
    my = MAG_W'(sy[NUM_W-1] ? -sy : sy);
    mz = MAG_W'(sz[NUM_W-1] ? -sz : sz);
    // Ties keep the lower axis: strict compares only.
    pick_y = my > mx;
    m_xy   = pick_y ? my : mx;
    pick_z = mz > m_xy;
    side_nxt.degen = (mx == '0) && (my == '0) && (mz == '0);
    if (pick_z) begin
      major_nxt     = mz;
      side_nxt.face = sz[NUM_W-1] ? FACE_NEG_Z : FACE_POS_Z;
    end else if (pick_y) begin
      major_nxt     = my;
      side_nxt.face = sy[NUM_W-1] ? FACE_NEG_Y : FACE_POS_Y;
    end else begin
      major_nxt     = mx;
      side_nxt.face = sx[NUM_W-1] ? FACE_NEG_X : FACE_POS_X;
    end
    if (side_nxt.degen) begin
      side_nxt.face = FACE_POS_X;
    end
    unique case (side_nxt.face)
      FACE_NEG_X: begin num_u_nxt = sy;  num_v_nxt = sz;  end
      FACE_POS_X: begin num_u_nxt = -sy; num_v_nxt = sz;  end
      FACE_NEG_Y: begin num_u_nxt = -sx; num_v_nxt = sz;  end
      FACE_POS_Y: begin num_u_nxt = sx;  num_v_nxt = sz;  end
      FACE_NEG_Z: begin num_u_nxt = sx;  num_v_nxt = sy;  end
      FACE_POS_Z: begin num_u_nxt = sx;  num_v_nxt = -sy; end
      default:    begin num_u_nxt = '0;  num_v_nxt = '0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r  <= side_nxt;
      major_r <= major_nxt;
      num_u_r <= num_u_nxt;
      num_v_r <= num_v_nxt;
    end
  end

endmodule

// ----- hw/rtl/cdfuv_cell.sv -----
// One CORDIC vectoring step for both face coordinates, registered.
module cdfuv_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [cdfuv_pkg::STEP_W-1:0]    step,
  input  logic                            in_valid,
  input  cdfuv_pkg::side_t                in_side,
  input  cdfuv_pkg::lane_t                in_u,
  input  cdfuv_pkg::lane_t                in_v,
  output logic                            valid_r,
  output cdfuv_pkg::side_t                side_r,
  output cdfuv_pkg::lane_t                u_r,
  output cdfuv_pkg::lane_t                v_r
);
  import cdfuv_pkg::*;

  function automatic lane_t rotate(input lane_t a, input logic [STEP_W-1:0] s,
                                   input logic signed [ANG_W-1:0] t);
    lane_t                  r;
    logic signed [DP_W-1:0] xs, ys;
    xs = a.x >>> s;
    ys = a.y >>> s;
    if (!a.y[DP_W-1]) begin
      r.x = a.x + ys;
      r.y = a.y - xs;
      r.z = a.z + t;
    end else begin
      r.x = a.x - ys;
      r.y = a.y + xs;
      r.z = a.z - t;
    end
    return r;
  endfunction

  logic signed [ANG_W-1:0] coef;
  lane_t                   u_nxt, v_nxt;

  always_comb begin
    coef  = atan_coef(step);
    u_nxt = rotate(in_u, step, coef);
    v_nxt = rotate(in_v, step, coef);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      u_r    <= u_nxt;
      v_r    <= v_nxt;
    end
  end

endmodule

// ----- hw/rtl/cdfuv_round.sv -----
// Back stage: clamp the angles to one octant, round to output precision.
module cdfuv_round (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  cdfuv_pkg::side_t                   in_side,
  input  logic signed [cdfuv_pkg::ANG_W-1:0] z_u,
  input  logic signed [cdfuv_pkg::ANG_W-1:0] z_v,
  output logic                               valid_r,
  output cdfuv_pkg::side_t                   side_r,
  output logic signed [cdfuv_pkg::OUT_W-1:0] u_r,
  output logic signed [cdfuv_pkg::OUT_W-1:0] v_r
);
  import cdfuv_pkg::*;

  function automatic logic signed [OUT_W-1:0] clamp_round(input logic signed [ANG_W-1:0] z);
    logic signed [ANG_W-1:0] zc, zs;
    if (z > ANG_LIM) begin
      zc = ANG_LIM;
    end else if (z < -ANG_LIM) begin
      zc = -ANG_LIM;
    end else begin
      zc = z;
    end
    zs = (zc + ANG_HALF) >>> ROUND_SHIFT;
    return OUT_W'(zs);
  endfunction

  logic signed [OUT_W-1:0] u_nxt, v_nxt;

  always_comb begin
    // Zero vector: drop the angles, report the origin.
    u_nxt = in_side.degen ? '0 : clamp_round(z_u);
    v_nxt = in_side.degen ? '0 : clamp_round(z_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      u_r    <= u_nxt;
      v_r    <= v_nxt;
    end
  end

endmodule

// ----- hw/rtl/cdfuv_checker.sv -----
// Port-level checks for the cube face block, bound to its top level.
`include "cube_direction_to_face_uv_macros.svh"

module cdfuv_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [cdfuv_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tuser
);
  import cdfuv_pkg::*;

  logic        [FACE_W-1:0] out_face;
  logic signed [OUT_W-1:0]  out_u;
  logic                     coords_zero;
  logic                     u_ok;

  assign out_face    = out_tdata[FACE_W-1:0];
  assign out_u       = out_tdata[FACE_W +: OUT_W];
  assign coords_zero = (out_tdata[OUT_FIELDS_W-1:FACE_W] == '0);
  // In [-1, 1]: a negative value keeps the bit under the sign set, a positive
  // one reaches that bit only at exactly 1.0.
  assign u_ok = out_u[OUT_W-1] ? out_u[OUT_W-2]
                               : !(out_u[OUT_W-2] && (out_u[FRAC_BITS-1:0] != '0));

  // Hold a stalled result.
  `CDFUV_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // A zero vector reports face +x at the origin.
  `CDFUV_ASSERT_SAME(a_degen_shape, out_tvalid && out_tuser, (out_face == FACE_POS_X) && coords_zero)

  // Face codes stay within the six faces.
  `CDFUV_ASSERT_SAME(a_face_range, out_tvalid, out_face <= FACE_POS_Z)

  // The u coordinate stays within [-1, 1].
  `CDFUV_ASSERT_SAME(a_u_range, out_tvalid, u_ok)

  // Back-pressure toward the source only follows a stall at the output.
  `CDFUV_ASSERT_SAME(a_ready_cause, !in_tready, $past(out_tvalid && !out_tready))

endmodule

bind cube_direction_to_face_uv cdfuv_checker u_cdfuv_checker (.*);
